@@ rtl/core/hbrc_pkg.sv @@
// Shared types and constants for the headset button resistance check.
// Used by the channel interfaces and every module of the block; depends on nothing.
package hbrc_pkg;

	localparam int ACT_W      = 3;
	localparam int RAW_W      = 16;
	localparam int V_W        = 12;
	localparam int R_W        = 21;
	localparam int VERD_W     = 2;
	localparam int BTN_W      = 3;
	localparam int RB_W       = 16;
	localparam int VB_W       = 12;
	localparam int WIN_W      = 10;
	localparam int IDX_W      = 4;
	localparam int CFG_DATA_W = 16;
	localparam int DEN_W      = 14;
	localparam int PRV_W      = 29;
	localparam int MAG_W      = 27;
	localparam int DIVS_W     = 13;
	localparam int FIFO_DEPTH = 4;

	localparam int SPAN_SHIFT = 15;
	localparam int SPAN_MASK  = 32767;
	localparam int V_MIN      = -2048;
	localparam int V_MAX      = 2047;
	localparam int R_MIN      = -1048576;
	localparam int R_MAX      = 1048575;

	typedef logic [ACT_W-1:0]          action_t;
	typedef logic signed [RAW_W-1:0]   raw_t;
	typedef logic signed [V_W-1:0]     volt_t;
	typedef logic signed [R_W-1:0]     ohm_t;
	typedef logic [VERD_W-1:0]         verdict_t;
	typedef logic [BTN_W-1:0]          button_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     reg_data_t;

	localparam action_t ACT_PLAY     = 3'd0;
	localparam action_t ACT_VOLUP    = 3'd1;
	localparam action_t ACT_VOLDOWN  = 3'd2;
	localparam action_t ACT_SPARE    = 3'd3;
	localparam action_t ACT_IDENTIFY = 3'd4;

	localparam verdict_t VERD_PASS    = 2'd0;
	localparam verdict_t VERD_FAIL    = 2'd1;
	localparam verdict_t VERD_NOPRESS = 2'd2;

	localparam button_t BTN_NONE    = 3'd0;
	localparam button_t BTN_PLAY    = 3'd1;
	localparam button_t BTN_VOLUP   = 3'd2;
	localparam button_t BTN_VOLDOWN = 3'd3;
	localparam button_t BTN_SPARE   = 3'd4;

	localparam reg_idx_t REG_BIAS_R   = 4'd0;
	localparam reg_idx_t REG_BIAS_V   = 4'd1;
	localparam reg_idx_t REG_VOLUP_LO = 4'd2;
	localparam reg_idx_t REG_VOLUP_HI = 4'd3;
	localparam reg_idx_t REG_VOLDN_LO = 4'd4;
	localparam reg_idx_t REG_VOLDN_HI = 4'd5;
	localparam reg_idx_t REG_SPARE_LO = 4'd6;
	localparam reg_idx_t REG_SPARE_HI = 4'd7;

	localparam logic [RB_W-1:0]  RST_BIAS_R   = 16'd2200;
	localparam logic [VB_W-1:0]  RST_BIAS_V   = 12'd2200;
	localparam logic [WIN_W-1:0] RST_VOLUP_LO = 10'd237;
	localparam logic [WIN_W-1:0] RST_VOLUP_HI = 10'd243;
	localparam logic [WIN_W-1:0] RST_VOLDN_LO = 10'd465;
	localparam logic [WIN_W-1:0] RST_VOLDN_HI = 10'd475;
	localparam logic [WIN_W-1:0] RST_SPARE_LO = 10'd133;
	localparam logic [WIN_W-1:0] RST_SPARE_HI = 10'd137;

	typedef struct packed {
		logic [RB_W-1:0]  bias_r;
		logic [VB_W-1:0]  bias_v;
		logic [WIN_W-1:0] volup_lo;
		logic [WIN_W-1:0] volup_hi;
		logic [WIN_W-1:0] voldn_lo;
		logic [WIN_W-1:0] voldn_hi;
		logic [WIN_W-1:0] spare_lo;
		logic [WIN_W-1:0] spare_hi;
	} cfg_t;

	typedef struct packed {
		action_t                 action;
		volt_t                   v;
		logic signed [DEN_W-1:0] denom;
		logic signed [PRV_W-1:0] prod;
		logic                    nonpos;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

@@ rtl/core/hbrc_if.sv @@
// Handshake channel interfaces for samples, results and register writes.
// Depends on hbrc_pkg for the payload types.
interface hbrc_req_if import hbrc_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	raw_t    raw_sample;

	modport source (output valid, output action, output raw_sample, input ready);
	modport sink (input valid, input action, input raw_sample, output ready);
endinterface

interface hbrc_rsp_if import hbrc_pkg::*; ();
	logic     valid;
	logic     ready;
	volt_t    voltage_mv;
	ohm_t     resistance_ohm;
	verdict_t verdict;
	button_t  detected_button;

	modport source (output valid, output voltage_mv, output resistance_ohm,
		output verdict, output detected_button, input ready);
	modport sink (input valid, input voltage_mv, input resistance_ohm,
		input verdict, input detected_button, output ready);
endinterface

interface hbrc_cfg_if import hbrc_pkg::*; ();
	logic      valid;
	logic      ready;
	reg_idx_t  index;
	reg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/hbrc_regs.sv @@
// Configuration register file: bias divider values and button windows.
// Depends on hbrc_pkg and the hbrc_cfg_if channel.
module hbrc_regs import hbrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hbrc_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bias_r   <= RST_BIAS_R;
			regs_q.bias_v   <= RST_BIAS_V;
			regs_q.volup_lo <= RST_VOLUP_LO;
			regs_q.volup_hi <= RST_VOLUP_HI;
			regs_q.voldn_lo <= RST_VOLDN_LO;
			regs_q.voldn_hi <= RST_VOLDN_HI;
			regs_q.spare_lo <= RST_SPARE_LO;
			regs_q.spare_hi <= RST_SPARE_HI;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BIAS_R:   regs_q.bias_r   <= cfg.data[RB_W-1:0];
				REG_BIAS_V:   regs_q.bias_v   <= cfg.data[VB_W-1:0];
				REG_VOLUP_LO: regs_q.volup_lo <= cfg.data[WIN_W-1:0];
				REG_VOLUP_HI: regs_q.volup_hi <= cfg.data[WIN_W-1:0];
				REG_VOLDN_LO: regs_q.voldn_lo <= cfg.data[WIN_W-1:0];
				REG_VOLDN_HI: regs_q.voldn_hi <= cfg.data[WIN_W-1:0];
				REG_SPARE_LO: regs_q.spare_lo <= cfg.data[WIN_W-1:0];
				REG_SPARE_HI: regs_q.spare_hi <= cfg.data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/hbrc_front.sv @@
// Front end: accepts samples, scales them to millivolts and prepares the divider operands.
// Depends on hbrc_pkg and the hbrc_req_if channel; feeds hbrc_fifo.
module hbrc_front import hbrc_pkg::*; #(
	parameter int FULL_SCALE_MV = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	hbrc_req_if.sink   req,
	input  cfg_t       regs,
	input  fifo_stat_t stat,
	output logic       push,
	output q_entry_t   push_data
);

	localparam int FS_W = $clog2(FULL_SCALE_MV + 1);
	localparam int SC_W = RAW_W + FS_W + 1;
	localparam int QW   = SC_W - SPAN_SHIFT;
	localparam logic [FS_W-1:0] FS_U = FS_W'(FULL_SCALE_MV);

	logic                   adv;
	logic                   vld_s1;
	action_t                action_s1;
	logic signed [SC_W-1:0] scaled_s1;

	logic signed [SC_W-1:0] adj;
	logic signed [QW-1:0]   quo;
	volt_t                  v_d;

	logic     vld_s2;
	q_entry_t ent_s2;
	q_entry_t ent_d;

	assign adv       = !stat.full;
	assign req.ready = adv;
	assign push      = vld_s2 && adv;
	assign push_data = ent_s2;

	always_comb begin
		adj = scaled_s1 + (scaled_s1[SC_W-1] ? SC_W'(SPAN_MASK) : '0);
		quo = $signed(adj[SC_W-1:SPAN_SHIFT]);
		if (quo > V_MAX) begin
			v_d = V_W'(V_MAX);
		end else if (quo < V_MIN) begin
			v_d = V_W'(V_MIN);
		end else begin
			v_d = V_W'(quo);
		end
		ent_d.action = action_s1;
		ent_d.v      = v_d;
		ent_d.denom  = $signed({2'b00, regs.bias_v}) - DEN_W'(v_d);
		ent_d.prod   = PRV_W'(v_d) * PRV_W'($signed({1'b0, regs.bias_r}));
		ent_d.nonpos = (ent_d.denom <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= req.action;
			scaled_s1 <= SC_W'(req.raw_sample) * SC_W'($signed({1'b0, FS_U}));
			ent_s2    <= ent_d;
		end
	end

endmodule

@@ rtl/core/hbrc_fifo.sv @@
// Short queue between the front end and the divider back end.
// Depends on hbrc_pkg for the entry and status types.
module hbrc_fifo import hbrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  q_entry_t   push_data,
	input  logic       pop,
	output q_entry_t   pop_data,
	output fifo_stat_t stat
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	q_entry_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue read while empty");

endmodule

@@ rtl/core/hbrc_back.sv @@
// Back end: pipelined restoring divider, saturation, window checks and the result register.
// Depends on hbrc_pkg and the hbrc_rsp_if channel; drains hbrc_fifo.
module hbrc_back import hbrc_pkg::*; #(
	parameter int MAX_VALID_OHM = 1000
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       regs,
	input  fifo_stat_t stat,
	input  q_entry_t   pop_data,
	output logic       pop,
	hbrc_rsp_if.source rsp
);

	localparam int DIV_STEPS = MAG_W;

	typedef struct packed {
		action_t            action;
		volt_t              v;
		logic               nonpos;
		logic               neg;
		logic [DIVS_W-1:0]  divisor;
		logic [DIVS_W-1:0]  rem;
		logic [MAG_W-1:0]   quo;
	} div_st_t;

	function automatic div_st_t div_step(div_st_t s);
		div_st_t         o;
		logic [DIVS_W:0] part;
		logic [DIVS_W:0] diff;
		o    = s;
		part = {s.rem, s.quo[MAG_W-1]};
		diff = part - {1'b0, s.divisor};
		if (part >= {1'b0, s.divisor}) begin
			o.rem = diff[DIVS_W-1:0];
			o.quo = {s.quo[MAG_W-2:0], 1'b1};
		end else begin
			o.rem = part[DIVS_W-1:0];
			o.quo = {s.quo[MAG_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic in_win(ohm_t r, logic [WIN_W-1:0] lo, logic [WIN_W-1:0] hi);
		return (r >= $signed({{(R_W-WIN_W){1'b0}}, lo}))
			&& (r <= $signed({{(R_W-WIN_W){1'b0}}, hi}));
	endfunction

	logic                adv;
	div_st_t             div_q [DIV_STEPS+1];
	logic [DIV_STEPS:0]  div_vld_q;
	div_st_t             load_d;
	logic [PRV_W-1:0]    abs_prod;

	logic signed [MAG_W:0] r_full;
	ohm_t                  r_d;

	logic     res_vld_q;
	action_t  res_action_q;
	volt_t    res_v_q;
	logic     res_np_q;
	ohm_t     res_r_q;

	logic     hit_play, hit_up, hit_down, hit_spare, in_rng;
	logic     single, ident, sel_hit;
	button_t  sel_btn;
	verdict_t verd_d;
	button_t  btn_d;

	logic     out_vld_q;
	volt_t    out_v_q;
	ohm_t     out_r_q;
	verdict_t out_verd_q;
	button_t  out_btn_q;

	assign adv = !out_vld_q || rsp.ready;
	assign pop = adv && !stat.empty;

	assign rsp.valid           = out_vld_q;
	assign rsp.voltage_mv      = out_v_q;
	assign rsp.resistance_ohm  = out_r_q;
	assign rsp.verdict         = out_verd_q;
	assign rsp.detected_button = out_btn_q;

	always_comb begin
		abs_prod       = pop_data.prod[PRV_W-1] ? PRV_W'(-pop_data.prod)
			: PRV_W'(pop_data.prod);
		load_d.action  = pop_data.action;
		load_d.v       = pop_data.v;
		load_d.nonpos  = pop_data.nonpos;
		load_d.neg     = pop_data.prod[PRV_W-1];
		load_d.divisor = pop_data.nonpos ? DIVS_W'(1) : pop_data.denom[DIVS_W-1:0];
		load_d.rem     = '0;
		load_d.quo     = abs_prod[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_q <= '0;
			res_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			div_vld_q <= {div_vld_q[DIV_STEPS-1:0], !stat.empty};
			res_vld_q <= div_vld_q[DIV_STEPS];
			out_vld_q <= res_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_q[0] <= load_d;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_q[k] <= div_step(div_q[k-1]);
			end
		end
	end

	always_comb begin
		r_full = div_q[DIV_STEPS].neg ? -$signed({1'b0, div_q[DIV_STEPS].quo})
			: $signed({1'b0, div_q[DIV_STEPS].quo});
		if (div_q[DIV_STEPS].nonpos || r_full > R_MAX) begin
			r_d = R_W'(R_MAX);
		end else if (r_full < R_MIN) begin
			r_d = R_W'(R_MIN);
		end else begin
			r_d = R_W'(r_full);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_action_q <= div_q[DIV_STEPS].action;
			res_v_q      <= div_q[DIV_STEPS].v;
			res_np_q     <= div_q[DIV_STEPS].nonpos;
			res_r_q      <= r_d;
		end
	end

	always_comb begin
		hit_play  = (res_r_q == '0);
		hit_up    = in_win(res_r_q, regs.volup_lo, regs.volup_hi);
		hit_down  = in_win(res_r_q, regs.voldn_lo, regs.voldn_hi);
		hit_spare = in_win(res_r_q, regs.spare_lo, regs.spare_hi);
		in_rng    = (res_r_q >= 0) && (res_r_q <= MAX_VALID_OHM);
		single    = 1'b0;
		ident     = 1'b0;
		sel_hit   = 1'b0;
		sel_btn   = BTN_NONE;
		case (res_action_q)
			ACT_PLAY: begin
				single  = 1'b1;
				sel_hit = hit_play;
				sel_btn = BTN_PLAY;
			end
			ACT_VOLUP: begin
				single  = 1'b1;
				sel_hit = hit_up;
				sel_btn = BTN_VOLUP;
			end
			ACT_VOLDOWN: begin
				single  = 1'b1;
				sel_hit = hit_down;
				sel_btn = BTN_VOLDOWN;
			end
			ACT_SPARE: begin
				single  = 1'b1;
				sel_hit = hit_spare;
				sel_btn = BTN_SPARE;
			end
			ACT_IDENTIFY: begin
				ident = 1'b1;
			end
			default: begin
			end
		endcase
		verd_d = VERD_NOPRESS;
		btn_d  = BTN_NONE;
		if (!res_np_q) begin
			if (single && in_rng) begin
				verd_d = sel_hit ? VERD_PASS : VERD_FAIL;
				btn_d  = sel_hit ? sel_btn : BTN_NONE;
			end else if (ident) begin
				verd_d = VERD_PASS;
				if (hit_play) begin
					btn_d = BTN_PLAY;
				end else if (hit_up) begin
					btn_d = BTN_VOLUP;
				end else if (hit_down) begin
					btn_d = BTN_VOLDOWN;
				end else if (hit_spare) begin
					btn_d = BTN_SPARE;
				end else begin
					verd_d = VERD_NOPRESS;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_v_q    <= res_v_q;
			out_r_q    <= res_r_q;
			out_verd_q <= verd_d;
			out_btn_q  <= btn_d;
		end
	end

	a_pass_has_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_verd_q == VERD_PASS |-> out_btn_q != BTN_NONE)
		else $error("in-spec result without a button");

	a_other_no_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_verd_q != VERD_PASS |-> out_btn_q == BTN_NONE)
		else $error("button reported on a result that is not in spec");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(div_vld_q) && $stable(res_vld_q))
		else $error("divider pipeline moved while the result was stalled");

endmodule

@@ rtl/core/headset_button_resistance_check.sv @@
// Headset button resistance check. Each transfer on req carries one signed converter sample
// and a test selector; each transfer on rsp returns the millivolt reading, the solved
// button resistance, a verdict and the detected button. One sample is accepted per cycle
// while rsp keeps up. A sample passes two front-end stages, the four-entry queue, an
// operand register, 27 one-bit-per-stage divider stages, a saturation stage and the
// result register. Registers are written over cfg, always ready; the user must write them
// only while the block is idle, which the block itself does not enforce.
module headset_button_resistance_check import hbrc_pkg::*; #(
	parameter int FULL_SCALE_MV = 2048,
	parameter int MAX_VALID_OHM = 1000
) (
	input  logic       clk,
	input  logic       arst_n,
	hbrc_req_if.sink   req,
	hbrc_rsp_if.source rsp,
	hbrc_cfg_if.sink   cfg
);

	cfg_t       regs;
	fifo_stat_t stat;
	logic       push;
	logic       pop;
	q_entry_t   push_data;
	q_entry_t   pop_data;

	hbrc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	hbrc_front #(
		.FULL_SCALE_MV (FULL_SCALE_MV)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.regs      (regs),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	hbrc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	hbrc_back #(
		.MAX_VALID_OHM (MAX_VALID_OHM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.stat     (stat),
		.pop_data (pop_data),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
